FILE: sv/irt_pkg.sv
// shared types and codes for the interval range table
`default_nettype none
package irt_pkg;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EVAL  = 6'b000010,
		ST_DEL   = 6'b000100,
		ST_INS_E = 6'b001000,
		ST_INS_B = 6'b010000,
		ST_DONE  = 6'b100000
	} irt_state_t;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic FUNC_ASSIGN = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef struct packed {
		logic init;
		logic shl;
		logic ins;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: sv/irt_cell.sv
// one boundary cell of the table row: key, value, valid and compares
`default_nettype none
module irt_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 8,
	parameter bit FIRST      = 1'b0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire irt_pkg::cell_ctl_t      ctl,
	input  wire logic [VALUE_BITS-1:0]   init_value,
	input  wire logic [KEY_BITS-1:0]     lo_key,
	input  wire logic [KEY_BITS-1:0]     hi_key,
	input  wire logic [KEY_BITS-1:0]     ins_key,
	input  wire logic [VALUE_BITS-1:0]   ins_value,
	input  wire logic [KEY_BITS-1:0]     left_key,
	input  wire logic [VALUE_BITS-1:0]   left_value,
	input  wire logic                    left_valid,
	input  wire logic                    left_lt,
	input  wire logic [KEY_BITS-1:0]     right_key,
	input  wire logic [VALUE_BITS-1:0]   right_value,
	input  wire logic                    right_valid,
	output logic [KEY_BITS-1:0]          key,
	output logic [VALUE_BITS-1:0]        value,
	output logic                         valid,
	output logic                         lt_lo,
	output logic                         le_hi
);
	import irt_pkg::*;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  valid_q;

	assign key   = key_q;
	assign value = value_q;
	assign valid = valid_q;
	assign lt_lo = valid_q & (key_q < lo_key);
	assign le_hi = valid_q & (key_q <= hi_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			value_q <= '0;
			valid_q <= FIRST;
		end else if (ctl.init) begin
			key_q   <= '0;
			value_q <= init_value;
			valid_q <= FIRST;
		end else if (ctl.shl && !lt_lo) begin
			key_q   <= right_key;
			value_q <= right_value;
			valid_q <= right_valid;
		end else if (ctl.ins && !lt_lo) begin
			if (left_lt) begin
				key_q   <= ins_key;
				value_q <= ins_value;
				valid_q <= 1'b1;
			end else begin
				key_q   <= left_key;
				value_q <= left_value;
				valid_q <= left_valid;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/interval_range_table.sv
// Interval range table: a sorted row of ENTRIES boundary cells maps the whole signed key
// space to values. An assign item gives new_value to [key_begin, key_end); a lookup item
// returns the value of the last boundary at or below lookup_key. A lookup goes from EVAL
// straight to DONE; an assign goes on through DEL, where the cell row shifts by one position
// per cycle until no boundary in [key_begin, key_end] is left, then INS_E and INS_B. Empty or
// refused assigns also go from EVAL straight to DONE. The table is ready for the next item
// in the same cycle that the result is presented, later while an earlier result still waits.
// Writing base_value resets the table to one boundary.
`default_nettype none
module interval_range_table #(
	parameter int ENTRIES    = 32,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    func,
	input  wire logic signed [KEY_BITS-1:0] key_begin,
	input  wire logic signed [KEY_BITS-1:0] key_end,
	input  wire logic [VALUE_BITS-1:0]   new_value,
	input  wire logic signed [KEY_BITS-1:0] lookup_key,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [VALUE_BITS-1:0]        found_value,
	output logic [1:0]                   status,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [VALUE_BITS-1:0]   base_value
);
	import irt_pkg::*;

	irt_state_t            state_q;
	logic                  func_q;
	logic [KEY_BITS-1:0]   b_q, e_q, look_q;
	logic [VALUE_BITS-1:0] val_q, vend_q;
	logic                  add_b_q, add_e_q;
	logic [VALUE_BITS-1:0] res_found_q, out_found_q;
	logic [1:0]            res_status_q, out_status_q;
	logic                  out_valid_q;

	cell_ctl_t             ctl;
	logic [KEY_BITS-1:0]   hi_bus, ins_key;
	logic [VALUE_BITS-1:0] ins_value;

	logic [KEY_BITS-1:0]   key_w [ENTRIES];
	logic [VALUE_BITS-1:0] val_w [ENTRIES];
	logic [ENTRIES-1:0]    vld_w, lt_w, le_w;

	logic [ENTRIES-1:0]    last_hi, last_lo, in_r;
	logic [VALUE_BITS-1:0] v_hi, v_lo;
	logic                  add_b, add_e, d1, d2, full, del_any;

	assign in_ready    = (state_q == ST_IDLE);
	assign cfg_ready   = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign found_value = out_found_q;
	assign status      = out_status_q;

	assign hi_bus = (func_q == FUNC_LOOKUP) ? look_q : e_q;

	always_comb begin
		ctl.init  = cfg_valid && cfg_ready;
		ctl.shl   = 1'b0;
		ctl.ins   = 1'b0;
		ins_key   = e_q;
		ins_value = vend_q;
		case (state_q)
			ST_DEL:   ctl.shl = del_any;
			ST_INS_E: ctl.ins = add_e_q;
			ST_INS_B: begin
				ctl.ins   = add_b_q;
				ins_key   = b_q;
				ins_value = val_q;
			end
			default: ;
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			logic [KEY_BITS-1:0]   lk, rk;
			logic [VALUE_BITS-1:0] lv, rv;
			logic                  lval, rval, llt;
			if (g == 0) begin : g_left0
				assign lk = '0;
				assign lv = '0;
				assign lval = 1'b0;
				assign llt = 1'b1;
			end else begin : g_left
				assign lk = key_w[g-1];
				assign lv = val_w[g-1];
				assign lval = vld_w[g-1];
				assign llt = lt_w[g-1];
			end
			if (g == ENTRIES - 1) begin : g_right_end
				assign rk = '0;
				assign rv = '0;
				assign rval = 1'b0;
			end else begin : g_right
				assign rk = key_w[g+1];
				assign rv = val_w[g+1];
				assign rval = vld_w[g+1];
			end
			irt_cell #(
				.KEY_BITS(KEY_BITS),
				.VALUE_BITS(VALUE_BITS),
				.FIRST(g == 0)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.init_value(base_value),
				.lo_key(b_q),
				.hi_key(hi_bus),
				.ins_key(ins_key),
				.ins_value(ins_value),
				.left_key(lk),
				.left_value(lv),
				.left_valid(lval),
				.left_lt(llt),
				.right_key(rk),
				.right_value(rv),
				.right_valid(rval),
				.key(key_w[g]),
				.value(val_w[g]),
				.valid(vld_w[g]),
				.lt_lo(lt_w[g]),
				.le_hi(le_w[g])
			);
		end
	endgenerate

	always_comb begin
		last_hi = le_w & ~{1'b0, le_w[ENTRIES-1:1]};
		last_lo = lt_w & ~{1'b0, lt_w[ENTRIES-1:1]};
		in_r    = vld_w & ~lt_w & le_w;
		v_hi    = '0;
		v_lo    = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (last_hi[i]) v_hi = v_hi | val_w[i];
			if (last_lo[i]) v_lo = v_lo | val_w[i];
		end
		add_b   = !(lt_w[0] && (v_lo == val_q));
		add_e   = (v_hi != val_q);
		d1      = |in_r;
		d2      = |(in_r & {1'b0, in_r[ENTRIES-1:1]});
		del_any = d1;
		full    = (add_b && add_e && !d1 && vld_w[ENTRIES-2])
			|| (add_b && add_e && d1 && !d2 && vld_w[ENTRIES-1])
			|| ((add_b ^ add_e) && !d1 && vld_w[ENTRIES-1]);
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			b_q    <= {~key_begin[KEY_BITS-1], key_begin[KEY_BITS-2:0]};
			e_q    <= {~key_end[KEY_BITS-1], key_end[KEY_BITS-2:0]};
			look_q <= {~lookup_key[KEY_BITS-1], lookup_key[KEY_BITS-2:0]};
			val_q  <= new_value;
		end
		if (state_q == ST_EVAL) begin
			vend_q  <= v_hi;
			add_b_q <= add_b;
			add_e_q <= add_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_found_q  <= '0;
			res_status_q <= STATUS_DONE;
			out_found_q  <= '0;
			out_status_q <= STATUS_DONE;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_DONE)) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_EVAL;
				ST_EVAL: begin
					state_q <= ST_DONE;
					res_found_q  <= '0;
					res_status_q <= STATUS_DONE;
					if (func_q == FUNC_LOOKUP) begin
						res_found_q <= v_hi;
					end else if (b_q >= e_q) begin
						res_status_q <= STATUS_EMPTY;
					end else if (full) begin
						res_status_q <= STATUS_FULL;
					end else begin
						state_q <= ST_DEL;
					end
				end
				ST_DEL:   if (!del_any) state_q <= ST_INS_E;
				ST_INS_E: state_q <= ST_INS_B;
				ST_INS_B: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_found_q  <= res_found_q;
						out_status_q <= res_status_q;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: test/tb_interval_range_table.sv
// self-checking testbench for the interval range table: random and directed assigns and lookups
`timescale 1ns / 1ps
`default_nettype none
module tb_interval_range_table;
	import irt_pkg::*;

	localparam int NCELLS = 32;

	typedef struct packed {
		logic        func;
		logic [31:0] kb;
		logic [31:0] ke;
		logic [7:0]  nv;
		logic [31:0] lk;
	} op_t;

	typedef struct packed {
		logic [7:0] found;
		logic [1:0] status;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, func = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
	logic signed [31:0] key_begin = '0, key_end = '0, lookup_key = '0;
	logic [7:0] new_value = '0, base_value = '0;
	logic in_ready, out_valid, cfg_ready;
	logic [7:0] found_value;
	logic [1:0] status;

	interval_range_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.key_begin(key_begin), .key_end(key_end), .new_value(new_value),
		.lookup_key(lookup_key),
		.out_valid(out_valid), .out_ready(out_ready),
		.found_value(found_value), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .base_value(base_value)
	);

	// shadow table, keys held biased so unsigned order matches signed
	logic [31:0] tbl_key[$];
	logic [7:0]  tbl_val[$];
	op_t  pending_ops[$];
	res_t expected_res[$];
	int errors = 0, cycles = 0, results_seen = 0, n_full = 0, n_empty = 0;
	bit tx_idle_ok = 1'b1, rx_idle_ok = 1'b1, rx_hold = 1'b0;
	bit in_fire = 1'b0;
	int tx_gap = 0, rx_gap = 0;
	logic [7:0] key_pool[8];

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("interval_range_table verification failed");
			$finish;
		end
	end

	// input item taken at the last rising edge
	always @(posedge clk) in_fire <= arst_n && in_valid && in_ready;

	function automatic logic [7:0] value_at(logic [31:0] k);
		logic [7:0] v;
		v = tbl_val[0];
		foreach (tbl_key[i]) begin
			if (tbl_key[i] <= k) v = tbl_val[i];
			else break;
		end
		return v;
	endfunction

	function automatic logic [1:0] apply_assign(logic [31:0] b, logic [31:0] e, logic [7:0] v);
		logic [31:0] nk[$];
		logic [7:0] nvq[$];
		logic [7:0] v_end;
		if (b >= e) return STATUS_EMPTY;
		v_end = value_at(e);
		foreach (tbl_key[i]) begin
			if (tbl_key[i] >= b) break;
			nk.push_back(tbl_key[i]);
			nvq.push_back(tbl_val[i]);
		end
		if (nk.size() == 0 || nvq[$] != v) begin
			nk.push_back(b);
			nvq.push_back(v);
		end
		if (v_end != v) begin
			nk.push_back(e);
			nvq.push_back(v_end);
		end
		foreach (tbl_key[i]) begin
			if (tbl_key[i] <= e) continue;
			if (nk.size() > NCELLS) return STATUS_FULL;
			if (nvq[$] == tbl_val[i]) continue;
			nk.push_back(tbl_key[i]);
			nvq.push_back(tbl_val[i]);
		end
		if (nk.size() > NCELLS) return STATUS_FULL;
		tbl_key = nk;
		tbl_val = nvq;
		return STATUS_DONE;
	endfunction

	function automatic res_t predict_result(op_t op);
		res_t r;
		r = '0;
		if (op.func == FUNC_LOOKUP) r.found = value_at(op.lk ^ 32'h8000_0000);
		else r.status = apply_assign(op.kb ^ 32'h8000_0000, op.ke ^ 32'h8000_0000, op.nv);
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire) begin
				expected_res.push_back(predict_result(pending_ops.pop_front()));
				if ($urandom_range(0, 15) == 0 && tx_idle_ok) tx_gap = $urandom_range(1, 7);
			end
			if (!in_valid || in_fire) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					in_valid <= 1'b1;
					func <= pending_ops[0].func;
					key_begin <= pending_ops[0].kb;
					key_end <= pending_ops[0].ke;
					new_value <= pending_ops[0].nv;
					lookup_key <= pending_ops[0].lk;
				end else in_valid <= 1'b0;
			end
			if (rx_hold) out_ready <= 1'b0;
			else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 15) == 0 && rx_idle_ok) rx_gap = $urandom_range(1, 7);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_res.size() == 0) begin
				$error("result with nothing expected: found_value %0d status %0d",
					found_value, status);
				errors++;
			end else begin
				exp_r = expected_res.pop_front();
				if (status == STATUS_FULL) n_full++;
				if (status == STATUS_EMPTY) n_empty++;
				if (found_value !== exp_r.found) begin
					$error("found_value expected %0d actual %0d", exp_r.found, found_value);
					errors++;
				end
				if (status !== exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, status);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return {24'h0, key_pool[$urandom_range(0, 7)]};
			2: return 32'h8000_0000 + $urandom_range(0, 3);
			3: return 32'h7fff_fffc + $urandom_range(0, 3);
			default: return $urandom_range(0, 80) - 40;
		endcase
	endfunction

	function automatic op_t rand_op();
		op_t op;
		logic [31:0] a, b;
		op.func = ($urandom_range(0, 9) < 4) ? FUNC_LOOKUP : FUNC_ASSIGN;
		a = pick_key();
		b = pick_key();
		if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
			op.kb = b;
			op.ke = a;
		end else begin
			op.kb = a;
			op.ke = b;
		end
		op.nv = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
		op.lk = pick_key();
		return op;
	endfunction

	function automatic op_t mk(logic f, logic [31:0] kb, logic [31:0] ke, logic [7:0] v,
			logic [31:0] lk);
		op_t op;
		op.func = f;
		op.kb = kb;
		op.ke = ke;
		op.nv = v;
		op.lk = lk;
		return op;
	endfunction

	task automatic drain();
		wait (pending_ops.size() == 0 && !in_valid && expected_res.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_base(logic [7:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		base_value <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		tbl_key = '{32'h0};
		tbl_val = '{v};
	endtask

	initial begin
		foreach (key_pool[i]) key_pool[i] = 8'($urandom());
		tbl_key = '{32'h0};
		tbl_val = '{8'h0};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, both functions, empty, equal value before begin, full
		pending_ops.push_back(mk(FUNC_LOOKUP, 0, 0, 0, 32'h8000_0000));
		pending_ops.push_back(mk(FUNC_LOOKUP, 0, 0, 0, 32'h7fff_ffff));
		pending_ops.push_back(mk(FUNC_ASSIGN, 32'h8000_0000, 32'h7fff_ffff, 8'hff, 0));
		pending_ops.push_back(mk(FUNC_LOOKUP, 0, 0, 0, 32'h7fff_fffe));
		pending_ops.push_back(mk(FUNC_LOOKUP, 0, 0, 0, 32'h7fff_ffff));
		pending_ops.push_back(mk(FUNC_ASSIGN, 5, 5, 8'h11, 0));
		pending_ops.push_back(mk(FUNC_ASSIGN, 10, 3, 8'h11, 0));
		pending_ops.push_back(mk(FUNC_ASSIGN, 10, 20, 8'hff, 0));
		pending_ops.push_back(mk(FUNC_ASSIGN, 10, 20, 8'h00, 0));
		pending_ops.push_back(mk(FUNC_ASSIGN, 15, 30, 8'h00, 0));
		pending_ops.push_back(mk(FUNC_LOOKUP, 0, 0, 0, 29));
		pending_ops.push_back(mk(FUNC_LOOKUP, 0, 0, 0, 30));
		pending_ops.push_back(mk(FUNC_LOOKUP, 0, 0, 0, 9));
		for (int i = 0; i < 20; i++)
			pending_ops.push_back(mk(FUNC_ASSIGN, 100 + 4 * i, 102 + 4 * i, 8'(i + 1), 0));
		pending_ops.push_back(mk(FUNC_ASSIGN, 32'hffff_ff00, 32'h0000_7000, 8'h55, 0));
		drain();
		write_base(8'hff);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) begin
				tx_idle_ok = 1'b0;
				rx_idle_ok = 1'b0;
			end
			for (int i = 0; i < 300; i++) pending_ops.push_back(rand_op());
			if (ph == 2) begin
				rx_hold = 1'b1;
				repeat (200) @(posedge clk);
				rx_hold = 1'b0;
			end
			drain();
			if (ph < 5) write_base((ph == 0) ? 8'h00 : 8'($urandom()));
		end

		$display("ran %0d results: %0d refused full, %0d empty intervals, six base settings",
			results_seen, n_full, n_empty);
		if (errors == 0) $display("interval_range_table verification clean");
		else $display("interval_range_table verification failed");
		$finish;
	end
endmodule
`default_nettype wire
